// File: sv/wrpm_pkg.sv
// Shared constants, types and state encodings of the windowed RMS and peak meter.
package wrpm_pkg;

  localparam int MAX_CHANNELS_DEF      = 64;
  localparam int WINDOW_PERIODS_DEF    = 400;
  localparam int SAMPLE_BITS_DEF       = 24;
  localparam int MAX_PERIOD_FRAMES_DEF = 4096;

  localparam int CH_W        = 6;
  localparam int LEVEL_W     = 24;
  localparam int ACT_W       = 7;
  localparam int FRM_W       = 13;
  localparam int PSUM_W      = 58;
  localparam int HIST_SHIFT  = 12;
  localparam int HSUM_W      = PSUM_W - HIST_SHIFT;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'd8388608;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_ENABLE      = 2'd2;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd1;
  localparam logic [FRM_W-1:0] FRAMES_RESET = 13'd256;

  typedef struct packed {
    logic [ACT_W-1:0] nch;
    logic             enable;
  } front_cfg_t;

  // one channel's period totals handed from front to back at period close
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [HSUM_W-1:0]  hsum;
    logic [LEVEL_W-1:0] peak;
    logic               last;
  } close_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] peak;
    logic               last;
  } report_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_UPD,
    F_WALK_RD,
    F_WALK_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_UPD,
    B_SCAN,
    B_SCAN_END,
    B_DIV,
    B_SQRT,
    B_PUSH
  } back_state_t;

endpackage

// File: sv/wrpm_fifo.sv
// Small first-in first-out queue of packed items.
module wrpm_fifo import wrpm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: sv/wrpm_front.sv
// Front end: takes samples, keeps per-channel period sums and peaks, walks them out at close.
module wrpm_front import wrpm_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  front_cfg_t             cfg,
  input  logic                   hold,
  input  logic                   push,
  input  logic [CH_W-1:0]        channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last_of_period,
  output logic                   full,
  output logic                   q_push,
  output close_item_t            q_data,
  input  logic                   q_full
);

  localparam int CI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SQ_W = 2 * SAMPLE_BITS;

  typedef struct packed {
    logic [PSUM_W-1:0]  psum;
    logic [LEVEL_W-1:0] peak;
  } acc_t;

  front_state_t state, state_next;

  acc_t                   mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] valid;
  acc_t                   rdata;
  logic                   rvalid;
  acc_t                   cur;
  logic [CI_W-1:0]        raddr;

  logic [CH_W-1:0]        ch_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic                   last_r;
  logic                   elig_r;
  logic [SQ_W-1:0]        sq_r;
  logic [ACT_W-1:0]       cnt;

  logic [SAMPLE_BITS-1:0] mag;
  logic [PSUM_W:0]        sum;
  logic                   accept;
  logic                   walk_done;
  logic                   acc_we;
  logic                   clear_all;

  assign mag       = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign cur       = rvalid ? rdata : '0;
  assign sum       = {1'b0, cur.psum} + (PSUM_W+1)'(sq_r);
  assign walk_done = (cnt == cfg.nch - 1'b1);
  assign raddr     = (state == F_WALK_RD || state == F_WALK_PUSH) ? cnt[CI_W-1:0]
                                                               : ch_r[CI_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:      if (accept) state_next = F_MUL;
      F_MUL:       state_next = F_UPD;
      F_UPD: begin
        if (last_r && cfg.enable) state_next = F_WALK_RD;
        else                      state_next = F_IDLE;
      end
      F_WALK_RD:   state_next = F_WALK_PUSH;
      F_WALK_PUSH: begin
        if (!q_full) state_next = walk_done ? F_IDLE : F_WALK_RD;
      end
      default:     state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full      = 1'b1;
    accept    = 1'b0;
    acc_we    = 1'b0;
    q_push    = 1'b0;
    clear_all = 1'b0;
    case (state)
      F_IDLE: begin
        full   = hold;
        accept = push && !hold;
      end
      F_UPD: begin
        acc_we    = elig_r;
        clear_all = last_r && !cfg.enable;
      end
      F_WALK_PUSH: begin
        q_push    = !q_full;
        clear_all = !q_full && walk_done;
      end
      default: ;
    endcase
  end

  assign q_data.ch   = cnt[CH_W-1:0];
  assign q_data.hsum = cur.psum[PSUM_W-1:HIST_SHIFT];
  assign q_data.peak = cur.peak;
  assign q_data.last = walk_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      valid <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (clear_all) begin
        valid <= '0;
      end else if (acc_we) begin
        valid[ch_r[CI_W-1:0]] <= 1'b1;
      end
      if (state == F_UPD) begin
        cnt <= '0;
      end else if (state == F_WALK_PUSH && !q_full) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= channel;
      mag_r  <= mag;
      last_r <= last_of_period;
      elig_r <= cfg.enable && (ACT_W'(channel) < cfg.nch);
    end
    sq_r <= mag_r * mag_r;
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      mem[ch_r[CI_W-1:0]].psum <= sum[PSUM_W] ? '1 : sum[PSUM_W-1:0];
      mem[ch_r[CI_W-1:0]].peak <= (LEVEL_W'(mag_r) > cur.peak) ? LEVEL_W'(mag_r) : cur.peak;
    end
    rdata  <= mem[raddr];
    rvalid <= valid[raddr];
  end

endmodule

// File: sv/wrpm_back.sv
// Back end: history update, window peak scan, mean-square division and square root.
module wrpm_back import wrpm_pkg::*; #(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int WINDOW_PERIODS = WINDOW_PERIODS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [FRM_W-1:0] frames,
  output logic             busy,
  input  logic             q_empty,
  output logic             q_pop,
  input  close_item_t      q_data,
  input  logic             o_full,
  output logic             o_push,
  output report_t          o_data
);

  localparam int NENT   = MAX_CHANNELS * WINDOW_PERIODS;
  localparam int AW     = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CI_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SLOT_W = (WINDOW_PERIODS > 1) ? $clog2(WINDOW_PERIODS) : 1;
  localparam int TOT_W  = HSUM_W + $clog2(WINDOW_PERIODS + 1);
  localparam int DSR_W  = $clog2(WINDOW_PERIODS + 1) + FRM_W;
  localparam int QW     = TOT_W + HIST_SHIFT;
  localparam int SQ_W   = QW + (QW % 2);
  localparam int RT_W   = SQ_W / 2;
  localparam int SR_W   = RT_W + 2;
  localparam int CW_W   = $clog2(QW);

  typedef struct packed {
    logic [HSUM_W-1:0]  hsum;
    logic [LEVEL_W-1:0] peak;
  } hist_t;

  back_state_t state, state_next;

  hist_t            hist [NENT];
  logic [TOT_W-1:0] wt   [MAX_CHANNELS];
  hist_t            hrdata;
  logic [TOT_W-1:0] wtrdata;
  logic [AW-1:0]    hraddr;
  logic [AW-1:0]    hwaddr;
  hist_t            hwdata;
  logic             hwe;
  logic             wtwe;
  logic [CI_W-1:0]  wtwaddr;
  logic [TOT_W-1:0] wtwdata;

  logic [AW-1:0]      clr_cnt;
  close_item_t        item;
  logic [AW-1:0]      base;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  v;
  logic               sv;
  logic [LEVEL_W-1:0] pk_max;
  logic [TOT_W-1:0]   tot;
  logic [DSR_W-1:0]   dsr;
  logic [DSR_W-1:0]   dv_rem;
  logic [QW-1:0]      dv_q;
  logic [CW_W-1:0]    cw;
  logic [SQ_W-1:0]    sq_val;
  logic [SR_W-1:0]    sq_rem;
  logic [RT_W-1:0]    root;

  logic [TOT_W-1:0]   tot_new;
  logic [LEVEL_W-1:0] pk_upd;
  logic [DSR_W:0]     dv_sh;
  logic               dv_bit;
  logic [QW-1:0]      dv_q_next;
  logic [SR_W:0]      sq_sh;
  logic [SR_W:0]      sq_trial;
  logic               sq_bit;
  logic [RT_W-1:0]    root_next;
  logic               clr_done;
  logic               scan_done;

  assign busy      = (state == B_CLEAR);
  assign clr_done  = (clr_cnt == AW'(NENT - 1));
  assign scan_done = (v == SLOT_W'(WINDOW_PERIODS - 1));
  assign tot_new   = wtrdata - TOT_W'(hrdata.hsum) + TOT_W'(item.hsum);
  assign pk_upd    = (sv && hrdata.peak > pk_max) ? hrdata.peak : pk_max;

  // restoring division, one quotient bit per cycle
  assign dv_sh     = {dv_rem, dv_q[QW-1]};
  assign dv_bit    = (dv_sh >= (DSR_W+1)'(dsr));
  assign dv_q_next = {dv_q[QW-2:0], dv_bit};

  // square root, one root bit per cycle from two radicand bits
  assign sq_sh     = {sq_rem[SR_W-2:0], sq_val[SQ_W-1:SQ_W-2]};
  assign sq_trial  = (SR_W+1)'({root, 2'b01});
  assign sq_bit    = (sq_sh >= sq_trial);
  assign root_next = {root[RT_W-2:0], sq_bit};

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR:    if (clr_done) state_next = B_IDLE;
      B_IDLE:     if (!q_empty) state_next = B_RD;
      B_RD:       state_next = B_UPD;
      B_UPD:      state_next = B_SCAN;
      B_SCAN:     if (scan_done) state_next = B_SCAN_END;
      B_SCAN_END: state_next = B_DIV;
      B_DIV:      if (cw == CW_W'(QW - 1)) state_next = B_SQRT;
      B_SQRT:     if (cw == CW_W'(RT_W - 1)) state_next = B_PUSH;
      B_PUSH:     if (!o_full) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    o_push  = 1'b0;
    hwe     = 1'b0;
    wtwe    = 1'b0;
    hwaddr  = base + AW'(slot);
    hwdata  = {item.hsum, item.peak};
    hraddr  = base + AW'(v);
    wtwaddr = item.ch[CI_W-1:0];
    wtwdata = tot_new;
    case (state)
      B_CLEAR: begin
        hwe     = 1'b1;
        hwaddr  = clr_cnt;
        hwdata  = '0;
        wtwe    = (clr_cnt < AW'(MAX_CHANNELS));
        wtwaddr = clr_cnt[CI_W-1:0];
        wtwdata = '0;
      end
      B_IDLE:  q_pop = !q_empty;
      B_RD:    hraddr = base + AW'(slot);
      B_UPD: begin
        hwe  = 1'b1;
        wtwe = 1'b1;
      end
      B_PUSH:  o_push = !o_full;
      default: ;
    endcase
  end

  assign o_data.ch   = item.ch;
  assign o_data.rms  = (root > RT_W'(FULL_SCALE)) ? FULL_SCALE : root[LEVEL_W-1:0];
  assign o_data.peak = pk_max;
  assign o_data.last = item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      slot    <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == B_UPD && item.last) begin
        slot <= (slot == SLOT_W'(WINDOW_PERIODS - 1)) ? '0 : slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sv <= (state == B_SCAN);
    case (state)
      B_IDLE: begin
        item <= q_data;
        base <= AW'(q_data.ch) * AW'(WINDOW_PERIODS);
      end
      B_UPD: begin
        tot    <= tot_new;
        v      <= '0;
        pk_max <= '0;
      end
      B_SCAN: begin
        v      <= v + 1'b1;
        pk_max <= pk_upd;
      end
      B_SCAN_END: begin
        pk_max <= pk_upd;
        dv_q   <= {tot, HIST_SHIFT'(0)};
        dv_rem <= '0;
        dsr    <= DSR_W'(frames) * DSR_W'(WINDOW_PERIODS);
        cw     <= '0;
      end
      B_DIV: begin
        dv_rem <= dv_bit ? DSR_W'(dv_sh - (DSR_W+1)'(dsr)) : dv_sh[DSR_W-1:0];
        dv_q   <= dv_q_next;
        if (cw == CW_W'(QW - 1)) begin
          sq_val <= SQ_W'(dv_q_next);
          sq_rem <= '0;
          root   <= '0;
          cw     <= '0;
        end else begin
          cw     <= cw + 1'b1;
        end
      end
      B_SQRT: begin
        sq_rem <= sq_bit ? SR_W'(sq_sh - sq_trial) : sq_sh[SR_W-1:0];
        sq_val <= {sq_val[SQ_W-3:0], 2'b00};
        root   <= root_next;
        cw     <= cw + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      hist[hwaddr] <= hwdata;
    end
    hrdata <= hist[hraddr];
    if (wtwe) begin
      wt[wtwaddr] <= wtwdata;
    end
    wtrdata <= wt[item.ch[CI_W-1:0]];
  end

`ifndef SYNTHESIS
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_pop) else $error("close queue popped during history clear");
  a_push_only_with_room: assert property (@(posedge clk) disable iff (rst)
    o_push |-> !o_full) else $error("report pushed into full queue");
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    slot < SLOT_W'(WINDOW_PERIODS) || WINDOW_PERIODS == 1) else $error("slot out of range");
  a_slot_moves_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == B_UPD && !item.last) |=> $stable(slot)) else $error("slot moved mid-period");
`endif

endmodule

// File: sv/windowed_rms_peak_meter.sv
// Top level of the multichannel windowed RMS and peak level meter.
// Input channel: push/full, one sample per item with its channel and a period-end mark.
// An item is taken when push is high and full is low. Each sample occupies the
// front end through accept, square and read-modify-write of the channel sum.
// When the meter is enabled, the period-end item then walks the active channels
// into a short close queue; full stays high during the walk.
// The back end handles one channel per close entry: history read and update,
// a scan of WINDOW_PERIODS history slots for the window peak (one memory read
// per cycle), a bit-serial division, a bit-serial square root and the report push.
// Result channel: empty/pop; the oldest report sits on the ports while empty is low.
// A stalled receiver backs up the report queue, then the back end, then the
// close queue, and finally full on the input side.
// After rst the history memory is cleared one entry per cycle, all
// MAX_CHANNELS * WINDOW_PERIODS entries (25600 by default); full is high meanwhile.
// Configuration writes are accepted at any time and take effect at once.
module windowed_rms_peak_meter import wrpm_pkg::*; #(
  parameter int MAX_CHANNELS      = MAX_CHANNELS_DEF,
  parameter int WINDOW_PERIODS    = WINDOW_PERIODS_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int MAX_PERIOD_FRAMES = MAX_PERIOD_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [CH_W-1:0]        channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last_of_period,
  output logic                   empty,
  input  logic                   pop,
  output logic [CH_W-1:0]        out_channel,
  output logic [LEVEL_W-1:0]     rms_level,
  output logic [LEVEL_W-1:0]     peak_level,
  output logic                   last_report
);

  logic [ACT_W-1:0] active_channels;
  logic [FRM_W-1:0] frames_per_period;
  logic             meter_enable;

  front_cfg_t       fcfg;
  logic [FRM_W-1:0] frames_eff;
  logic             busy;

  logic             cq_push, cq_full, cq_pop, cq_empty;
  close_item_t      cq_wdata, cq_rdata;
  logic             rq_push, rq_full;
  report_t          rq_wdata, rq_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels   <= ACTIVE_RESET;
      frames_per_period <= FRAMES_RESET;
      meter_enable      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ACTIVE_CHANNELS:   active_channels   <= cfg_data[ACT_W-1:0];
        CFG_FRAMES_PER_PERIOD: frames_per_period <= cfg_data[FRM_W-1:0];
        CFG_METER_ENABLE:      meter_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_channels == '0)                         fcfg.nch = ACT_W'(1);
    else if (active_channels > ACT_W'(MAX_CHANNELS))   fcfg.nch = ACT_W'(MAX_CHANNELS);
    else                                               fcfg.nch = active_channels;
    fcfg.enable = meter_enable;
    if (frames_per_period == '0)                           frames_eff = FRM_W'(1);
    else if (frames_per_period > FRM_W'(MAX_PERIOD_FRAMES)) frames_eff = FRM_W'(MAX_PERIOD_FRAMES);
    else                                                   frames_eff = frames_per_period;
  end

  wrpm_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (fcfg),
    .hold           (busy),
    .push           (push),
    .channel        (channel),
    .sample         (sample),
    .last_of_period (last_of_period),
    .full           (full),
    .q_push         (cq_push),
    .q_data         (cq_wdata),
    .q_full         (cq_full)
  );

  wrpm_fifo #(
    .WIDTH ($bits(close_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_close_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  wrpm_back #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .WINDOW_PERIODS (WINDOW_PERIODS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .frames  (frames_eff),
    .busy    (busy),
    .q_empty (cq_empty),
    .q_pop   (cq_pop),
    .q_data  (cq_rdata),
    .o_full  (rq_full),
    .o_push  (rq_push),
    .o_data  (rq_wdata)
  );

  wrpm_fifo #(
    .WIDTH ($bits(report_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_report_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign out_channel = rq_rdata.ch;
  assign rms_level   = rq_rdata.rms;
  assign peak_level  = rq_rdata.peak;
  assign last_report = rq_rdata.last;

endmodule

// File: verif/windowed_rms_peak_meter_test.sv
// Self-checking testbench for the windowed RMS and peak level meter.
module windowed_rms_peak_meter_test import wrpm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = MAX_CHANNELS_DEF;
  localparam int NSLOT = WINDOW_PERIODS_DEF;
  localparam longint unsigned SUM_CAP = (64'd1 << PSUM_W) - 1;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CH_W-1:0]       ch;
    logic [LEVEL_W-1:0]    smp;
    logic                  last;
    bit                    typed;
    logic [LEVEL_W-1:0]    rms_exp;
    logic [LEVEL_W-1:0]    peak_exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [CH_W-1:0] channel = '0;
  logic [LEVEL_W-1:0] sample = '0;
  logic last_of_period = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [CH_W-1:0] out_channel;
  logic [LEVEL_W-1:0] rms_level;
  logic [LEVEL_W-1:0] peak_level;
  logic last_report;

  windowed_rms_peak_meter DUT (.*);

  always #10 clk = ~clk;

  // meter image kept by the testbench
  logic [ACT_W-1:0]  act_reg;
  logic [FRM_W-1:0]  frm_reg;
  logic              en_reg;
  logic [PSUM_W-1:0] chan_sum [NCH];
  logic [LEVEL_W-1:0] chan_peak [NCH];
  logic [HSUM_W-1:0] hist_sum [NCH][NSLOT];
  logic [LEVEL_W-1:0] hist_peak [NCH][NSLOT];
  logic [54:0]       win_sum [NCH];
  int                slot_ptr;

  report_t pending_reports[$];
  int errors = 0;
  int items_sent = 0;
  int reports_seen = 0;
  int closes = 0;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  function automatic int live_channels();
    if (act_reg == 0) return 1;
    if (int'(act_reg) > NCH) return NCH;
    return int'(act_reg);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [LEVEL_W-1:0] rms_of(longint unsigned tot);
    longint unsigned frames, d, q, s;
    frames = (frm_reg == 0) ? 64'd1 : (frm_reg > FRM_W'(MAX_PERIOD_FRAMES_DEF)) ?
             64'(MAX_PERIOD_FRAMES_DEF) : 64'(frm_reg);
    d = 64'(NSLOT) * frames;
    q = ((tot / d) << 12) + (((tot % d) << 12) / d);
    s = int_sqrt(q);
    if (s > 64'(FULL_SCALE)) s = 64'(FULL_SCALE);
    return s[LEVEL_W-1:0];
  endfunction

  task automatic meter_reset();
    act_reg = ACTIVE_RESET;
    frm_reg = FRAMES_RESET;
    en_reg = 1'b1;
    slot_ptr = 0;
    for (int c = 0; c < NCH; c++) begin
      chan_sum[c] = '0;
      chan_peak[c] = '0;
      win_sum[c] = '0;
      for (int v = 0; v < NSLOT; v++) begin
        hist_sum[c][v] = '0;
        hist_peak[c][v] = '0;
      end
    end
  endtask

  // advance the image by one accepted item and queue the reports it causes
  task automatic meter_step(logic [CH_W-1:0] ch, logic [LEVEL_W-1:0] smp, logic last);
    int n;
    longint unsigned mag, sq, acc;
    logic [HSUM_W-1:0] h;
    logic [LEVEL_W-1:0] pk;
    report_t r;
    n = live_channels();
    if (en_reg && int'(ch) < n) begin
      mag = smp[LEVEL_W-1] ? (64'd1 << LEVEL_W) - 64'(smp) : 64'(smp);
      sq = mag * mag;
      acc = 64'(chan_sum[ch]);
      acc = (acc > SUM_CAP - sq) ? SUM_CAP : acc + sq;
      chan_sum[ch] = acc[PSUM_W-1:0];
      if (mag > 64'(chan_peak[ch])) chan_peak[ch] = mag[LEVEL_W-1:0];
    end
    if (!last) return;
    if (en_reg) begin
      closes++;
      for (int c = 0; c < n; c++) begin
        h = HSUM_W'(chan_sum[c] >> HIST_SHIFT);
        win_sum[c] = win_sum[c] - 55'(hist_sum[c][slot_ptr]) + 55'(h);
        hist_sum[c][slot_ptr] = h;
        hist_peak[c][slot_ptr] = chan_peak[c];
      end
      slot_ptr = (slot_ptr + 1) % NSLOT;
      for (int c = 0; c < n; c++) begin
        pk = '0;
        for (int v = 0; v < NSLOT; v++)
          if (hist_peak[c][v] > pk) pk = hist_peak[c][v];
        r.ch = CH_W'(c);
        r.rms = rms_of(64'(win_sum[c]));
        r.peak = pk;
        r.last = (c + 1 == n);
        pending_reports.push_back(r);
      end
    end
    for (int c = 0; c < NCH; c++) begin
      chan_sum[c] = '0;
      chan_peak[c] = '0;
    end
  endtask

  task automatic send_item(logic [CH_W-1:0] ch, logic [LEVEL_W-1:0] smp, logic last);
    int gap;
    gap = src_gaps ? int'($urandom_range(0, 11)) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    channel <= ch;
    sample <= smp;
    last_of_period <= last;
    do @(posedge clk); while (full);
    items_sent++;
    meter_step(ch, smp, last);
  endtask

  // wait until all reports are out, then let any silent work finish
  task automatic settle();
    if (push) begin
      push <= 1'b0;
      @(posedge clk);
    end
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_ACTIVE_CHANNELS:   act_reg = d[ACT_W-1:0];
      CFG_FRAMES_PER_PERIOD: frm_reg = d[FRM_W-1:0];
      CFG_METER_ENABLE:      en_reg = d[0];
      default: ;
    endcase
  endtask

  function automatic row_t item_row(logic [CH_W-1:0] ch, logic [LEVEL_W-1:0] smp, logic last);
    row_t r;
    r = '{ROW_ITEM, '0, '0, ch, smp, last, 1'b0, '0, '0};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    row_t r;
    r = '{ROW_CFG, idx, d, '0, '0, 1'b0, 1'b0, '0, '0};
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // result side: check each popped report, stall at random while sink_stalls is set
  initial begin
    int wait_left;
    report_t e;
    wait_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected report: ch %0d rms %0d peak %0d last %0b",
                     out_channel, rms_level, peak_level, last_report);
        end else begin
          e = pending_reports.pop_front();
          if (out_channel !== e.ch || rms_level !== e.rms || peak_level !== e.peak ||
              last_report !== e.last) begin
            errors++;
            if (errors <= 10)
              $display({"report mismatch: exp ch %0d rms %0d peak %0d last %0b, ",
                        "got ch %0d rms %0d peak %0d last %0b"},
                       e.ch, e.rms, e.peak, e.last,
                       out_channel, rms_level, peak_level, last_report);
          end
        end
        wait_left = sink_stalls ? int'($urandom_range(0, 11)) : 0;
        if (wait_left > 0) pop <= 1'b0;
      end else if (!pop) begin
        if (wait_left > 0) wait_left--;
        else pop <= 1'b1;
      end
    end
  end

  initial begin
    #500_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t plan[$];
    int nch;
    meter_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // full-scale negative sample alone in the window: rms and peak readable by hand
    plan.push_back('{ROW_ITEM, '0, '0, 6'd0, 24'h800000, 1'b1, 1'b1, 24'd26214, 24'd8388608});
    plan.push_back(item_row(6'd0, 24'h7FFFFF, 1'b0));
    plan.push_back(item_row(6'd5, 24'h123456, 1'b0));   // inactive channel
    plan.push_back(item_row(6'd63, 24'h000001, 1'b1));  // inactive channel closes period
    plan.push_back(cfg_row(CFG_ACTIVE_CHANNELS, 13'd0));
    plan.push_back(cfg_row(CFG_FRAMES_PER_PERIOD, 13'd0));
    plan.push_back(item_row(6'd0, 24'hFFFFFF, 1'b1));
    plan.push_back(cfg_row(CFG_FRAMES_PER_PERIOD, 13'h1FFF));
    plan.push_back(cfg_row(CFG_ACTIVE_CHANNELS, 13'd127));
    plan.push_back(item_row(6'd63, 24'h800001, 1'b0));
    plan.push_back(item_row(6'd32, 24'h400000, 1'b0));
    plan.push_back(item_row(6'd0, 24'h000000, 1'b1));
    plan.push_back(cfg_row(CFG_METER_ENABLE, 13'd0));
    plan.push_back(item_row(6'd0, 24'h7FFFFF, 1'b0));
    plan.push_back(item_row(6'd0, 24'h800000, 1'b1));   // disabled close, no report
    plan.push_back(cfg_row(CFG_METER_ENABLE, 13'd1));
    plan.push_back(cfg_row(CFG_ACTIVE_CHANNELS, 13'd2));
    plan.push_back(cfg_row(CFG_FRAMES_PER_PERIOD, 13'd1));
    plan.push_back(item_row(6'd1, 24'h2AAAAA, 1'b1));
    plan.push_back(item_row(6'd0, 24'h555555, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].ch, plan[i].smp, plan[i].last);
        if (plan[i].typed) begin
          pending_reports[$].rms = plan[i].rms_exp;
          pending_reports[$].peak = plan[i].peak_exp;
        end
      end
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < 5; ph++) begin
      nch = (ph == 3) ? 64 : int'($urandom_range(1, 6));
      write_reg(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(nch));
      write_reg(CFG_FRAMES_PER_PERIOD, CFG_DATA_W'($urandom_range(1, 4096)));
      write_reg(CFG_METER_ENABLE, (ph == 2) ? 13'd0 : 13'd1);
      if (ph == 2) write_reg(CFG_METER_ENABLE, 13'd1);
      src_gaps = (ph != 1);
      sink_stalls = (ph != 4);
      for (int k = 0; k < 19; k++)
        send_item(CH_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) :
                        $urandom_range(0, nch - 1)), rand_sample(),
                  $urandom_range(0, (ph == 3) ? 10 : 4) == 0);
      send_item(CH_W'($urandom_range(0, 63)), rand_sample(), 1'b1);
    end
    settle();

    $display("covered %0d items, %0d period closes, %0d reports checked",
             items_sent, closes, reports_seen);
    $display("settings: channel counts 0..127, frame counts 0..8191, meter on and off");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
